/* rtl/keyed_table_pair_with_equi_join_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the keyed table pair with equi-join
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYED_TABLE_PAIR_WITH_EQUI_JOIN_DEFINES_SVH
`define KEYED_TABLE_PAIR_WITH_EQUI_JOIN_DEFINES_SVH

// same-cycle implication
`define KPJ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KPJ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/kpj_pkg.sv */
// ----------------------------------------------------------------------------
// kpj_pkg
// Shared constants, codes and types of the keyed table pair with equi-join.
// ----------------------------------------------------------------------------
package kpj_pkg;

    localparam int KEY_W       = 8;
    localparam int VAL_W       = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 3;
    localparam int MAX_RESULTS = 16;
    localparam int PARENT_ROWS_DEF = 16;
    localparam int CHILD_ROWS_DEF  = 16;

    localparam logic [OP_W-1:0] OP_INS_PARENT = 2'd0;
    localparam logic [OP_W-1:0] OP_INS_CHILD  = 2'd1;
    localparam logic [OP_W-1:0] OP_JOIN       = 2'd2;

    localparam logic [ST_W-1:0] ST_INSERTED   = 3'd0;
    localparam logic [ST_W-1:0] ST_DUP_KEY    = 3'd1;
    localparam logic [ST_W-1:0] ST_NO_PARENT  = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL       = 3'd3;
    localparam logic [ST_W-1:0] ST_JOIN_PAIR  = 3'd4;
    localparam logic [ST_W-1:0] ST_JOIN_EMPTY = 3'd5;

    typedef struct packed {
        logic shift;
        logic load;
    } ring_ctl_t;

endpackage

/* rtl/kpj_cell.sv */
// ----------------------------------------------------------------------------
// kpj_cell
// One row of a table ring: takes its neighbor's row on shift, a new row on load.
// ----------------------------------------------------------------------------
module kpj_cell
    import kpj_pkg::*;
(
    input  logic               clk,
    input  ring_ctl_t          ctl,
    input  logic [KEY_W-1:0]   nbr_key,
    input  logic [VAL_W-1:0]   nbr_value,
    input  logic [KEY_W-1:0]   wr_key,
    input  logic [VAL_W-1:0]   wr_value,
    output logic [KEY_W-1:0]   row_key,
    output logic [VAL_W-1:0]   row_value
);

    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            key_reg   <= wr_key;
            value_reg <= wr_value;
        end
        else if (ctl.shift)
        begin
            key_reg   <= nbr_key;
            value_reg <= nbr_value;
        end
    end

    assign row_key   = key_reg;
    assign row_value = value_reg;

endmodule

/* rtl/kpj_ring.sv */
// ----------------------------------------------------------------------------
// kpj_ring
// Ring of row cells; one rotation step per shift, cell 0 is the head.
// ----------------------------------------------------------------------------
module kpj_ring
    import kpj_pkg::*;
#(
    parameter int ROWS = PARENT_ROWS_DEF,
    localparam int IW  = (ROWS > 1) ? $clog2(ROWS) : 1
)
(
    input  logic               clk,
    input  ring_ctl_t          ctl,
    input  logic [IW-1:0]      load_idx,
    input  logic [KEY_W-1:0]   load_key,
    input  logic [VAL_W-1:0]   load_value,
    output logic [KEY_W-1:0]   head_key,
    output logic [VAL_W-1:0]   head_value
);

    logic [KEY_W-1:0] keys   [ROWS];
    logic [VAL_W-1:0] values [ROWS];

    for (genvar i = 0; i < ROWS; i++)
    begin : g_cell
        ring_ctl_t cell_ctl;

        assign cell_ctl.shift = ctl.shift;
        assign cell_ctl.load  = ctl.load && (load_idx == IW'(i));

        kpj_cell u_cell (
            .clk       (clk),
            .ctl       (cell_ctl),
            .nbr_key   (keys[(i + 1) % ROWS]),
            .nbr_value (values[(i + 1) % ROWS]),
            .wr_key    (load_key),
            .wr_value  (load_value),
            .row_key   (keys[i]),
            .row_value (values[i])
        );
    end

    assign head_key   = keys[0];
    assign head_value = values[0];

endmodule

/* rtl/keyed_table_pair_with_equi_join.sv */
// ----------------------------------------------------------------------------
// keyed_table_pair_with_equi_join
// Parent and child keyed tables held in rotating cell rings, with equi-join.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. An insert (parent
// or child) runs one full rotation of the parent ring for the key check. A
// join rotates the child ring once for every parent row, then closes out the
// last result in a flush state. Opcode 3 starts no work and gives no result.
// An insert result appears in the cycle after its scan ends; a join pair is
// held until the next pair is found or the walk ends, so the last one can
// carry last. Each result shows for a single cycle with strobe high; the
// receiver cannot stall, so every strobe cycle is a transfer and must be
// taken then.
// ----------------------------------------------------------------------------
`include "keyed_table_pair_with_equi_join_defines.svh"

module keyed_table_pair_with_equi_join
    import kpj_pkg::*;
#(
    parameter int PARENT_ROWS = PARENT_ROWS_DEF,
    parameter int CHILD_ROWS  = CHILD_ROWS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OP_W-1:0]         opcode,
    input  logic [KEY_W-1:0]        key,
    input  logic signed [VAL_W-1:0] value,
    output logic                    strobe,
    output logic [ST_W-1:0]         status,
    output logic [KEY_W-1:0]        pair_key,
    output logic signed [VAL_W-1:0] parent_value,
    output logic signed [VAL_W-1:0] child_value,
    output logic                    last
);

    localparam int PW  = (PARENT_ROWS > 1) ? $clog2(PARENT_ROWS) : 1;
    localparam int CW  = (CHILD_ROWS > 1) ? $clog2(CHILD_ROWS) : 1;
    localparam int PCW = $clog2(PARENT_ROWS + 1);
    localparam int CCW = $clog2(CHILD_ROWS + 1);
    localparam int NW  = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_JOIN  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [PW-1:0]    ps_reg, ps_next;
    logic [CW-1:0]    cs_reg, cs_next;
    logic [NW-1:0]    n_reg, n_next;
    logic             hit_reg, hit_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [PCW-1:0]   pcount_reg, pcount_next;
    logic [CCW-1:0]   ccount_reg, ccount_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [KEY_W-1:0] pend_key_reg, pend_key_next;
    logic [VAL_W-1:0] pend_pv_reg, pend_pv_next;
    logic [VAL_W-1:0] pend_cv_reg, pend_cv_next;

    logic             strobe_reg;
    logic [ST_W-1:0]  status_reg;
    logic [KEY_W-1:0] okey_reg;
    logic [VAL_W-1:0] opv_reg;
    logic [VAL_W-1:0] ocv_reg;
    logic             last_reg;

    logic             emit;
    logic [ST_W-1:0]  e_status;
    logic [KEY_W-1:0] e_key;
    logic [VAL_W-1:0] e_pv;
    logic [VAL_W-1:0] e_cv;
    logic             e_last;

    ring_ctl_t        pctl;
    ring_ctl_t        cctl;
    logic [KEY_W-1:0] p_head_key;
    logic [VAL_W-1:0] p_head_value;
    logic [KEY_W-1:0] c_head_key;
    logic [VAL_W-1:0] c_head_value;

    logic             p_row_ok;
    logic             c_row_ok;
    logic             hit_now;
    logic             match;

    logic             unused_take;
    logic             counts_ok;
    logic             empty_out;

    kpj_ring #(.ROWS(PARENT_ROWS)) u_parent (
        .clk        (clk),
        .ctl        (pctl),
        .load_idx   (pcount_reg[PW-1:0]),
        .load_key   (key_reg),
        .load_value (value_reg),
        .head_key   (p_head_key),
        .head_value (p_head_value)
    );

    kpj_ring #(.ROWS(CHILD_ROWS)) u_child (
        .clk        (clk),
        .ctl        (cctl),
        .load_idx   (ccount_reg[CW-1:0]),
        .load_key   (key_reg),
        .load_value (value_reg),
        .head_key   (c_head_key),
        .head_value (c_head_value)
    );

    assign p_row_ok = PCW'(ps_reg) < pcount_reg;
    assign c_row_ok = CCW'(cs_reg) < ccount_reg;
    assign hit_now  = hit_reg || (p_row_ok && (p_head_key == key_reg));
    assign match    = p_row_ok && c_row_ok && (n_reg < NW'(MAX_RESULTS))
                      && (p_head_key == c_head_key);

    always_comb
    begin
        state_next      = state_reg;
        ps_next         = ps_reg;
        cs_next         = cs_reg;
        n_next          = n_reg;
        hit_next        = hit_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        value_next      = value_reg;
        pcount_next     = pcount_reg;
        ccount_next     = ccount_reg;
        pend_valid_next = pend_valid_reg;
        pend_key_next   = pend_key_reg;
        pend_pv_next    = pend_pv_reg;
        pend_cv_next    = pend_cv_reg;
        pctl            = '0;
        cctl            = '0;
        emit            = 1'b0;
        e_status        = ST_INSERTED;
        e_key           = key_reg;
        e_pv            = '0;
        e_cv            = '0;
        e_last          = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next         = opcode;
                    key_next        = key;
                    value_next      = value;
                    ps_next         = '0;
                    cs_next         = '0;
                    n_next          = '0;
                    hit_next        = 1'b0;
                    pend_valid_next = 1'b0;
                    case (opcode)
                        OP_INS_PARENT: state_next = S_SCAN;
                        OP_INS_CHILD:  state_next = S_SCAN;
                        OP_JOIN:       state_next = S_JOIN;
                        default:       state_next = S_IDLE;
                    endcase
                end
            end

            S_SCAN:
            begin
                pctl.shift = 1'b1;
                hit_next   = hit_now;
                ps_next    = ps_reg + PW'(1);
                if (ps_reg == PW'(PARENT_ROWS - 1))
                begin
                    ps_next    = '0;
                    state_next = S_IDLE;
                    emit       = 1'b1;
                    if (op_reg == OP_INS_PARENT)
                    begin
                        if (hit_now)
                            e_status = ST_DUP_KEY;
                        else if (pcount_reg == PCW'(PARENT_ROWS))
                            e_status = ST_FULL;
                        else
                        begin
                            e_status    = ST_INSERTED;
                            pctl.load   = 1'b1;
                            pcount_next = pcount_reg + PCW'(1);
                        end
                    end
                    else
                    begin
                        if (!hit_now)
                            e_status = ST_NO_PARENT;
                        else if (ccount_reg == CCW'(CHILD_ROWS))
                            e_status = ST_FULL;
                        else
                        begin
                            e_status    = ST_INSERTED;
                            cctl.load   = 1'b1;
                            ccount_next = ccount_reg + CCW'(1);
                        end
                    end
                end
            end

            S_JOIN:
            begin
                cctl.shift = 1'b1;
                if (match)
                begin
                    if (pend_valid_reg)
                    begin
                        emit     = 1'b1;
                        e_status = ST_JOIN_PAIR;
                        e_key    = pend_key_reg;
                        e_pv     = pend_pv_reg;
                        e_cv     = pend_cv_reg;
                        e_last   = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_key_next   = p_head_key;
                    pend_pv_next    = p_head_value;
                    pend_cv_next    = c_head_value;
                    n_next          = n_reg + NW'(1);
                end
                if (cs_reg == CW'(CHILD_ROWS - 1))
                begin
                    cs_next    = '0;
                    pctl.shift = 1'b1;
                    if (ps_reg == PW'(PARENT_ROWS - 1))
                    begin
                        ps_next    = '0;
                        state_next = S_FLUSH;
                    end
                    else
                        ps_next = ps_reg + PW'(1);
                end
                else
                    cs_next = cs_reg + CW'(1);
            end

            S_FLUSH:
            begin
                emit       = 1'b1;
                e_last     = 1'b1;
                state_next = S_IDLE;
                if (pend_valid_reg)
                begin
                    e_status = ST_JOIN_PAIR;
                    e_key    = pend_key_reg;
                    e_pv     = pend_pv_reg;
                    e_cv     = pend_cv_reg;
                end
                else
                begin
                    e_status = ST_JOIN_EMPTY;
                    e_key    = '0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ps_reg         <= '0;
            cs_reg         <= '0;
            n_reg          <= '0;
            hit_reg        <= 1'b0;
            pcount_reg     <= '0;
            ccount_reg     <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ps_reg         <= ps_next;
            cs_reg         <= cs_next;
            n_reg          <= n_next;
            hit_reg        <= hit_next;
            pcount_reg     <= pcount_next;
            ccount_reg     <= ccount_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        value_reg    <= value_next;
        pend_key_reg <= pend_key_next;
        pend_pv_reg  <= pend_pv_next;
        pend_cv_reg  <= pend_cv_next;
        status_reg   <= e_status;
        okey_reg     <= e_key;
        opv_reg      <= e_pv;
        ocv_reg      <= e_cv;
        last_reg     <= e_last;
    end

    assign busy         = (state_reg != S_IDLE);
    assign strobe       = strobe_reg;
    assign status       = status_reg;
    assign pair_key     = okey_reg;
    assign parent_value = opv_reg;
    assign child_value  = ocv_reg;
    assign last         = last_reg;

    assign unused_take = start && !busy && (opcode != OP_INS_PARENT)
                         && (opcode != OP_INS_CHILD) && (opcode != OP_JOIN);
    assign counts_ok   = (pcount_reg <= PCW'(PARENT_ROWS)) && (ccount_reg <= CCW'(CHILD_ROWS));
    assign empty_out   = strobe && (status == ST_JOIN_EMPTY);

    `KPJ_ASSERT_NOW(a_strobe_after_work, strobe, $past(busy), "result without operation in flight")
    `KPJ_ASSERT_NEXT(a_unused_op_one_cycle, unused_take, !busy && !strobe, "unused opcode left work")
    `KPJ_ASSERT_NOW(a_counts_in_range, 1'b1, counts_ok, "table count beyond capacity")
    `KPJ_ASSERT_NOW(a_empty_is_last, empty_out, last && (pair_key == '0), "empty join malformed")

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the keyed parent/child tables with equi-join.
// A queue of operations (directed corner cases, then random insert/join
// episodes with some noise) feeds a clocked driver that sends in bursts with
// random gaps. The driver runs a shadow copy of both tables on every
// transfer and queues the results it expects. A clocked monitor compares
// each strobed result field by field against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module testbench;
    import kpj_pkg::*;

    localparam int PARENT_ROWS = PARENT_ROWS_DEF;
    localparam int CHILD_ROWS  = CHILD_ROWS_DEF;
    localparam int TOTAL_ITEMS = 410;
    localparam int DRAIN_CYCLES = 2 * PARENT_ROWS * CHILD_ROWS + 40;
    localparam int CYCLE_LIMIT = 800000;
    localparam int PRINT_CAP = 40;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                    hold;
        logic [OP_W-1:0]         op;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } op_item_t;

    typedef struct packed {
        logic [ST_W-1:0]         status;
        logic [KEY_W-1:0]        pair_key;
        logic signed [VAL_W-1:0] parent_value;
        logic signed [VAL_W-1:0] child_value;
        logic                    last;
    } join_row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic [OP_W-1:0]         opcode = '0;
    logic [KEY_W-1:0]        key = '0;
    logic signed [VAL_W-1:0] value = '0;
    logic                    busy;
    logic                    strobe;
    logic [ST_W-1:0]         status;
    logic [KEY_W-1:0]        pair_key;
    logic signed [VAL_W-1:0] parent_value;
    logic signed [VAL_W-1:0] child_value;
    logic                    last;

    op_item_t  pending_ops[$];
    join_row_t expected_rows[$];
    op_item_t  cur_op;
    join_row_t want;

    logic [KEY_W-1:0] parent_key_tbl [PARENT_ROWS];
    logic [VAL_W-1:0] parent_val_tbl [PARENT_ROWS];
    logic [KEY_W-1:0] child_key_tbl [CHILD_ROWS];
    logic [VAL_W-1:0] child_val_tbl [CHILD_ROWS];
    int parent_fill = 0;
    int child_fill = 0;

    int burst_left = 0;
    int gap_left = 0;
    int cycle_count = 0;
    int error_count = 0;
    int ops_accepted = 0;
    int joins_accepted = 0;
    int results_checked = 0;
    int pairs_seen = 0;
    int full_rejects = 0;
    int drain_pauses = 0;

    keyed_table_pair_with_equi_join #(
        .PARENT_ROWS(PARENT_ROWS),
        .CHILD_ROWS (CHILD_ROWS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .key         (key),
        .value       (value),
        .strobe      (strobe),
        .status      (status),
        .pair_key    (pair_key),
        .parent_value(parent_value),
        .child_value (child_value),
        .last        (last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic void add_expected(input logic [ST_W-1:0] st, input logic [KEY_W-1:0] k,
                                         input logic [VAL_W-1:0] pv, input logic [VAL_W-1:0] cv,
                                         input logic lst);
        join_row_t r;
        r.status = st;
        r.pair_key = k;
        r.parent_value = pv;
        r.child_value = cv;
        r.last = lst;
        expected_rows.push_back(r);
        if (st == ST_FULL)
            full_rejects++;
    endfunction

    task automatic predict_results(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                                   input logic [VAL_W-1:0] v);
        int i;
        int j;
        int total;
        int n;
        logic found;
        found = 1'b0;
        for (i = 0; i < parent_fill; i++)
            if (parent_key_tbl[i] == k)
                found = 1'b1;
        case (op)
            OP_INS_PARENT:
            begin
                if (found)
                    add_expected(ST_DUP_KEY, k, '0, '0, 1'b1);
                else if (parent_fill >= PARENT_ROWS)
                    add_expected(ST_FULL, k, '0, '0, 1'b1);
                else
                begin
                    parent_key_tbl[parent_fill] = k;
                    parent_val_tbl[parent_fill] = v;
                    parent_fill++;
                    add_expected(ST_INSERTED, k, '0, '0, 1'b1);
                end
            end
            OP_INS_CHILD:
            begin
                if (!found)
                    add_expected(ST_NO_PARENT, k, '0, '0, 1'b1);
                else if (child_fill >= CHILD_ROWS)
                    add_expected(ST_FULL, k, '0, '0, 1'b1);
                else
                begin
                    child_key_tbl[child_fill] = k;
                    child_val_tbl[child_fill] = v;
                    child_fill++;
                    add_expected(ST_INSERTED, k, '0, '0, 1'b1);
                end
            end
            OP_JOIN:
            begin
                total = 0;
                for (i = 0; i < parent_fill; i++)
                    for (j = 0; j < child_fill; j++)
                        if (parent_key_tbl[i] == child_key_tbl[j] && total < MAX_RESULTS)
                            total++;
                if (total == 0)
                    add_expected(ST_JOIN_EMPTY, '0, '0, '0, 1'b1);
                else
                begin
                    n = 0;
                    for (i = 0; i < parent_fill; i++)
                        for (j = 0; j < child_fill; j++)
                            if (parent_key_tbl[i] == child_key_tbl[j] && n < total)
                            begin
                                add_expected(ST_JOIN_PAIR, parent_key_tbl[i], parent_val_tbl[i],
                                             child_val_tbl[j], n == total - 1);
                                n++;
                            end
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_op(input logic hold, input logic [OP_W-1:0] op,
                            input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v);
        op_item_t it;
        it.hold = hold;
        it.op = op;
        it.key = k;
        it.value = v;
        pending_ops.push_back(it);
    endtask

    // driver: one transfer per start && !busy edge, bursts separated by gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_results(opcode, key, value);
                ops_accepted++;
                if (opcode == OP_JOIN)
                    joins_accepted++;
            end
            if (!(start && busy))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_ops.size() != 0 &&
                         !(pending_ops[0].hold && expected_rows.size() != 0))
                begin
                    cur_op = pending_ops.pop_front();
                    if (cur_op.hold)
                        drain_pauses++;
                    opcode <= cur_op.op;
                    key <= cur_op.key;
                    value <= cur_op.value;
                    start <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                                  : $urandom_range(0, 8);
                        gap_left = $urandom_range(1, 24);
                    end
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be held off, every strobe is a transfer
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_rows.size() == 0)
                report_error($sformatf("unexpected result: status %0d key %0d", status, pair_key));
            else
            begin
                want = expected_rows.pop_front();
                results_checked++;
                if (want.status == ST_JOIN_PAIR)
                    pairs_seen++;
                if (status !== want.status)
                    report_error($sformatf("status %0d, want %0d", status, want.status));
                if (pair_key !== want.pair_key)
                    report_error($sformatf("pair_key %0d, want %0d", pair_key, want.pair_key));
                if (parent_value !== want.parent_value)
                    report_error($sformatf("parent_value %0d, want %0d",
                                           parent_value, want.parent_value));
                if (child_value !== want.child_value)
                    report_error($sformatf("child_value %0d, want %0d",
                                           child_value, want.child_value));
                if (last !== want.last)
                    report_error($sformatf("last %0b, want %0b", last, want.last));
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results still expected",
                 cycle_count, expected_rows.size());
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        logic [KEY_W-1:0] sent_parent_keys[$];
        logic [KEY_W-1:0] k;
        int np;
        int nc;
        int m;

        // directed corner cases
        queue_op(1'b0, OP_JOIN, 8'h00, 32'h0);
        queue_op(1'b0, OP_INS_CHILD, 8'h00, 32'h1234_5678);
        queue_op(1'b0, OP_INS_PARENT, 8'h00, 32'h8000_0000);
        queue_op(1'b0, OP_INS_PARENT, 8'hFF, 32'h7FFF_FFFF);
        queue_op(1'b0, OP_INS_PARENT, 8'h00, 32'h0000_0005);
        queue_op(1'b0, OP_INS_CHILD, 8'h00, 32'hFFFF_FFFF);
        queue_op(1'b0, OP_INS_CHILD, 8'hFF, 32'h0000_0000);
        queue_op(1'b0, OP_INS_CHILD, 8'h55, 32'h0000_0001);
        queue_op(1'b0, OP_UNUSED, 8'hAA, 32'h5555_5555);
        queue_op(1'b0, OP_INS_CHILD, 8'h00, 32'h7FFF_FFFF);
        queue_op(1'b1, OP_JOIN, 8'hFF, 32'hFFFF_FFFF);
        queue_op(1'b0, OP_INS_PARENT, 8'hAA, 32'h5555_5555);
        queue_op(1'b0, OP_INS_PARENT, 8'h55, 32'hAAAA_AAAA);
        queue_op(1'b0, OP_INS_CHILD, 8'h55, 32'h8000_0000);
        queue_op(1'b0, OP_UNUSED, 8'h55, 32'hAAAA_AAAA);
        queue_op(1'b0, OP_JOIN, 8'hAA, 32'h5555_5555);
        queue_op(1'b0, OP_INS_PARENT, 8'hFF, 32'h0000_0001);
        sent_parent_keys = '{8'h00, 8'hFF, 8'hAA, 8'h55};

        // random episodes: parents, children mostly of known parents, then a join
        while (pending_ops.size() < TOTAL_ITEMS)
        begin
            np = $urandom_range(0, 2);
            nc = $urandom_range(0, 3);
            for (m = 0; m < np; m++)
            begin
                if ($urandom_range(0, 9) < 6)
                    k = KEY_W'($urandom_range(0, 255));
                else
                    k = sent_parent_keys[$urandom_range(0, sent_parent_keys.size() - 1)];
                sent_parent_keys.push_back(k);
                queue_op(1'b0, OP_INS_PARENT, k, $urandom);
            end
            for (m = 0; m < nc; m++)
            begin
                if ($urandom_range(0, 9) < 8)
                    k = sent_parent_keys[$urandom_range(0, sent_parent_keys.size() - 1)];
                else
                    k = KEY_W'($urandom_range(0, 255));
                queue_op(1'b0, OP_INS_CHILD, k, $urandom);
            end
            if ($urandom_range(0, 9) == 0)
                queue_op(1'b0, OP_UNUSED, KEY_W'($urandom_range(0, 255)), $urandom);
            if ($urandom_range(0, 9) == 0)
                queue_op(1'b0, OP_INS_CHILD, KEY_W'($urandom_range(0, 255)), $urandom);
            queue_op($urandom_range(0, 11) == 0, OP_JOIN, KEY_W'($urandom_range(0, 255)),
                     $urandom);
        end

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_ops.size() != 0 || start)
            @(posedge clk);
        while (expected_rows.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d ops transferred (%0d joins), %0d results checked, %0d join pairs",
                 ops_accepted, joins_accepted, results_checked, pairs_seen);
        $display("summary: %0d table-full rejects, %0d drain pauses, final fill %0d/%0d rows",
                 full_rejects, drain_pauses, parent_fill, child_fill);
        if (error_count == 0 && expected_rows.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
